### rtl/cds_pkg.sv
// Shared types, constants and calendar functions of the calendar date shift unit.
// Used by cds_div12, calendar_date_shift_unit and the testbench; depends on nothing.
package cds_pkg;

  localparam int AMOUNT_BITS = 16;
  localparam int YEAR_W      = 14;
  localparam int MONTH_IN_W  = 7;
  localparam int DAY_IN_W    = 7;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int CMD_W       = 2;

  // working width of signed year and month sums, and of the divider magnitude
  localparam int SUM_W = ((AMOUNT_BITS > YEAR_W) ? AMOUNT_BITS : YEAR_W) + 2;
  localparam int DIV_W = SUM_W - 1;

  localparam int YEAR_MAX        = 9999;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int LEAP_DAY        = 29;

  // y divisible by 25 iff (y * inverse of 25 mod 2^14) <= floor((2^14 - 1) / 25)
  localparam logic [YEAR_W-1:0] INV25       = YEAR_W'(7209);
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = YEAR_W'(((1 << YEAR_W) - 1) / 25);

  localparam logic [CMD_W-1:0] CMD_DAYS   = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_MONTHS = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_YEARS  = CMD_W'(2);

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_BAD_DATE,
    STAT_RANGE
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_WAIT,
    ST_MONTH_YEAR,
    ST_MONTH_FIX,
    ST_YEAR_FIX,
    ST_DAY_STEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [MONTH_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] prod;
    logic              div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_LIMIT);
    return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd2:                   len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
      default:                len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

### rtl/cds_div12.sv
// Divide by twelve via a reciprocal multiply; start registers the dividend, then the quotient.
// Depends on cds_pkg for widths and the request and response structs.
module cds_div12
  import cds_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // x / 12 == (x >> 2) / 3; the rounded-up reciprocal of 3 is exact below 2^NUM_W
  localparam int NUM_W  = DIV_W - 2;
  localparam int QUO_SH = NUM_W + 1;
  localparam logic [NUM_W-1:0] RECIP3 = NUM_W'(((64'd1 << QUO_SH) + 64'd2) / 64'd3);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W-1:0]     num_r, num_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [2*NUM_W-1:0]   prod;
  logic [MONTH_W-1:0]   times12;

  assign prod    = {{NUM_W{1'b0}}, num_r[DIV_W-1:2]} * {{NUM_W{1'b0}}, RECIP3};
  assign times12 = {quo_r[0], 3'b000} + {quo_r[1:0], 2'b00};

  always_comb begin
    busy_nxt = 1'b0;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      num_nxt  = req.dividend;
    end else if (busy_r) begin
      quo_nxt  = {{(DIV_W - NUM_W + 1){1'b0}}, prod[2*NUM_W-1:QUO_SH]};
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = num_r[MONTH_W-1:0] - times12;

endmodule

### rtl/calendar_date_shift_unit.sv
// Calendar date shift unit: shifts a Gregorian date by days, months or years.
// Depends on cds_pkg and instantiates cds_div12.
//
// One beat in, one beat out; the unit works on one date at a time and holds
// in_ready low until the result is in the output register. A shift by months
// waits in ST_DIV_WAIT on the reciprocal divide by twelve. A shift by days
// walks the calendar one month per cycle. An invalid input date gives
// STAT_BAD_DATE. The next date is taken while a result still waits for
// out_ready.
module calendar_date_shift_unit
  import cds_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [YEAR_W-1:0]      in_start_year,
  input  logic [MONTH_IN_W-1:0]  in_start_month,
  input  logic [DAY_IN_W-1:0]    in_start_day,
  input  logic [AMOUNT_BITS-1:0] in_amount,
  input  logic [CMD_W-1:0]       in_command,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [YEAR_W-1:0]      out_result_year,
  output logic [MONTH_W-1:0]     out_result_month,
  output logic [DAY_W-1:0]       out_result_day,
  output logic [STATUS_W-1:0]    out_status
);

  localparam logic [SUM_W-1:0]   SUM_YEAR_MAX = SUM_W'(YEAR_MAX);
  localparam logic [YEAR_W-1:0]  YEAR_LAST    = YEAR_W'(YEAR_MAX);
  localparam logic [MONTH_W-1:0] MONTH_LAST   = MONTH_W'(MONTHS_PER_YEAR);
  localparam logic [DAY_W-1:0]   DAY_LEAP     = DAY_W'(LEAP_DAY);
  localparam logic [MONTH_W:0]   TWELVE       = (MONTH_W + 1)'(MONTHS_PER_YEAR);

  state_t                   state_r, state_nxt;
  status_t                  st_r, st_nxt;
  logic [YEAR_W-1:0]        y_r, y_nxt;
  logic [MONTH_IN_W-1:0]    m_raw_r, m_raw_nxt;
  logic [DAY_IN_W-1:0]      d_raw_r, d_raw_nxt;
  logic [MONTH_W-1:0]       m_r, m_nxt;
  logic [DAY_W-1:0]         d_r, d_nxt;
  logic [AMOUNT_BITS-1:0]   amt_r, amt_nxt;
  logic [CMD_W-1:0]         cmd_r, cmd_nxt;
  logic [AMOUNT_BITS-1:0]   rem_r, rem_nxt;
  logic                     back_r, back_nxt;
  logic                     neg_r, neg_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]        out_year_r, out_year_nxt;
  logic [MONTH_W-1:0]       out_month_r, out_month_nxt;
  logic [DAY_W-1:0]         out_day_r, out_day_nxt;
  status_t                  out_st_r, out_st_nxt;

  // shared calendar unit
  logic [YEAR_W-1:0]        cal_y;
  logic [MONTH_W-1:0]       cal_m;
  logic                     cal_leap;
  logic [DAY_W-1:0]         cal_dim;

  logic [MONTH_W-1:0]       prev_m;
  logic [YEAR_W-1:0]        prev_y;
  logic [SUM_W-1:0]         y_ext, amt_ext, ysum, nsum, nmag;
  logic [AMOUNT_BITS-1:0]   left_ext, d_ext;
  logic [DAY_W-1:0]         left;
  logic [SUM_W-1:0]         q_ext;
  logic [MONTH_W:0]         r_fix;
  logic                     y_in_ok, m_in_ok, d_in_ok;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  cds_div12 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign prev_m = (m_r == MONTH_W'(1)) ? MONTH_LAST : m_r - MONTH_W'(1);
  assign prev_y = (m_r == MONTH_W'(1)) ? y_r - YEAR_W'(1) : y_r;

  always_comb begin
    cal_y = y_r;
    cal_m = m_r;
    if (state_r == ST_CHECK) begin
      cal_m = m_raw_r[MONTH_W-1:0];
    end else if (state_r == ST_DAY_STEP && back_r) begin
      cal_y = prev_y;
      cal_m = prev_m;
    end
  end

  assign cal_leap = leap_year(cal_y);
  assign cal_dim  = month_days(cal_m, cal_leap);

  assign y_ext    = {{(SUM_W - YEAR_W){1'b0}}, y_r};
  assign amt_ext  = {{(SUM_W - AMOUNT_BITS){amt_r[AMOUNT_BITS-1]}}, amt_r};
  assign ysum     = y_ext + amt_ext;
  assign nsum     = {{(SUM_W - MONTH_W){1'b0}}, m_raw_r[MONTH_W-1:0]} - SUM_W'(1) + amt_ext;
  assign nmag     = nsum[SUM_W-1] ? -nsum : nsum;
  assign left     = cal_dim - d_r;
  assign left_ext = {{(AMOUNT_BITS - DAY_W){1'b0}}, left};
  assign d_ext    = {{(AMOUNT_BITS - DAY_W){1'b0}}, d_r};

  assign y_in_ok = (y_r != '0) && (y_r <= YEAR_LAST);
  assign m_in_ok = (m_raw_r != '0) && (m_raw_r <= MONTH_IN_W'(MONTHS_PER_YEAR));
  assign d_in_ok = (d_raw_r != '0) && (d_raw_r <= {{(DAY_IN_W - DAY_W){1'b0}}, cal_dim});

  assign q_ext = {1'b0, div_rsp.quotient};
  assign r_fix = (neg_r && div_rsp.remainder != '0) ?
                 TWELVE - {1'b0, div_rsp.remainder} : {1'b0, div_rsp.remainder};

  always_comb begin
    state_nxt        = state_r;
    st_nxt           = st_r;
    y_nxt            = y_r;
    m_raw_nxt        = m_raw_r;
    d_raw_nxt        = d_raw_r;
    m_nxt            = m_r;
    d_nxt            = d_r;
    amt_nxt          = amt_r;
    cmd_nxt          = cmd_r;
    rem_nxt          = rem_r;
    back_nxt         = back_r;
    neg_nxt          = neg_r;
    sum_nxt          = sum_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_year_nxt     = out_year_r;
    out_month_nxt    = out_month_r;
    out_day_nxt      = out_day_r;
    out_st_nxt       = out_st_r;
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = nmag[DIV_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          y_nxt     = in_start_year;
          m_raw_nxt = in_start_month;
          d_raw_nxt = in_start_day;
          amt_nxt   = in_amount;
          cmd_nxt   = in_command;
          st_nxt    = STAT_OK;
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        m_nxt = m_raw_r[MONTH_W-1:0];
        d_nxt = d_raw_r[DAY_W-1:0];
        if (!(y_in_ok && m_in_ok && d_in_ok)) begin
          st_nxt    = STAT_BAD_DATE;
          state_nxt = ST_FINISH;
        end else begin
          case (cmd_r)
            CMD_MONTHS: begin
              div_req.start = 1'b1;
              neg_nxt       = nsum[SUM_W-1];
              state_nxt     = ST_DIV_WAIT;
            end
            CMD_YEARS: begin
              if (ysum[SUM_W-1] || ysum == '0 || ysum > SUM_YEAR_MAX) begin
                st_nxt    = STAT_RANGE;
                state_nxt = ST_FINISH;
              end else begin
                y_nxt     = ysum[YEAR_W-1:0];
                state_nxt = ST_YEAR_FIX;
              end
            end
            default: begin
              back_nxt  = amt_r[AMOUNT_BITS-1];
              rem_nxt   = amt_r[AMOUNT_BITS-1] ? -amt_r : amt_r;
              state_nxt = ST_DAY_STEP;
            end
          endcase
        end
      end

      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (!neg_r) begin
            sum_nxt = q_ext;
          end else if (div_rsp.remainder == '0) begin
            sum_nxt = -q_ext;
          end else begin
            sum_nxt = ~q_ext;
          end
          m_nxt     = MONTH_W'(r_fix + (MONTH_W + 1)'(1));
          state_nxt = ST_MONTH_YEAR;
        end
      end

      ST_MONTH_YEAR: begin
        if ((y_ext + sum_r) == '0 || (y_ext + sum_r) > SUM_YEAR_MAX ||
            sum_nxt[SUM_W-1] && (y_ext + sum_r) > y_ext) begin
          st_nxt    = STAT_RANGE;
          state_nxt = ST_FINISH;
        end else begin
          y_nxt     = YEAR_W'(y_ext + sum_r);
          state_nxt = ST_MONTH_FIX;
        end
      end

      ST_MONTH_FIX: begin
        if (m_r == MONTH_W'(2) && d_r == DAY_LEAP && !cal_leap) begin
          m_nxt = MONTH_W'(3);
          d_nxt = DAY_W'(1);
        end else if (d_r > cal_dim) begin
          d_nxt = cal_dim;
        end
        state_nxt = ST_FINISH;
      end

      ST_YEAR_FIX: begin
        if (m_r == MONTH_W'(2) && d_r == DAY_LEAP && !cal_leap) begin
          d_nxt = DAY_W'(28);
        end
        state_nxt = ST_FINISH;
      end

      ST_DAY_STEP: begin
        if (!back_r) begin
          if (rem_r <= left_ext) begin
            d_nxt     = d_r + rem_r[DAY_W-1:0];
            state_nxt = ST_FINISH;
          end else if (m_r == MONTH_LAST && y_r == YEAR_LAST) begin
            st_nxt    = STAT_RANGE;
            state_nxt = ST_FINISH;
          end else begin
            rem_nxt = rem_r - left_ext - AMOUNT_BITS'(1);
            d_nxt   = DAY_W'(1);
            if (m_r == MONTH_LAST) begin
              y_nxt = y_r + YEAR_W'(1);
              m_nxt = MONTH_W'(1);
            end else begin
              m_nxt = m_r + MONTH_W'(1);
            end
          end
        end else begin
          if (rem_r < d_ext) begin
            d_nxt     = d_r - rem_r[DAY_W-1:0];
            state_nxt = ST_FINISH;
          end else if (m_r == MONTH_W'(1) && y_r == YEAR_W'(1)) begin
            st_nxt    = STAT_RANGE;
            state_nxt = ST_FINISH;
          end else begin
            rem_nxt = rem_r - d_ext;
            y_nxt   = prev_y;
            m_nxt   = prev_m;
            d_nxt   = cal_dim;
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          if (st_r == STAT_OK) begin
            out_year_nxt  = y_r;
            out_month_nxt = m_r;
            out_day_nxt   = d_r;
          end else begin
            out_year_nxt  = '0;
            out_month_nxt = '0;
            out_day_nxt   = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    st_r        <= st_nxt;
    y_r         <= y_nxt;
    m_raw_r     <= m_raw_nxt;
    d_raw_r     <= d_raw_nxt;
    m_r         <= m_nxt;
    d_r         <= d_nxt;
    amt_r       <= amt_nxt;
    cmd_r       <= cmd_nxt;
    rem_r       <= rem_nxt;
    back_r      <= back_nxt;
    neg_r       <= neg_nxt;
    sum_r       <= sum_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_year  = out_year_r;
  assign out_result_month = out_month_r;
  assign out_result_day   = out_day_r;
  assign out_status       = out_st_r;

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CHECK))
    else $error("accepted beat did not start the date check");

  a_fail_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |->
      (out_result_year == '0 && out_result_month == '0 && out_result_day == '0))
    else $error("failed shift carries a nonzero date");

  a_ok_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_OK) |->
      (out_result_month != '0 && out_result_month <= MONTH_LAST &&
       out_result_day != '0 && out_result_year != '0))
    else $error("good result holds an impossible date");

  a_walk_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DAY_STEP) |->
      (d_r != '0 && m_r != '0 && m_r <= MONTH_LAST && y_r != '0))
    else $error("day walk left the calendar");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_WAIT))
    else $error("divider finished outside the month shift");

endmodule

### tb/tb_calendar_date_shift_unit.sv
`timescale 1ns / 100ps
// Testbench for calendar_date_shift_unit: a directed table of dates, then random shifts.
// Each result is checked against a fixed row or an independent predictor; uses cds_pkg.
module tb_calendar_date_shift_unit
  import cds_pkg::*;
();

  localparam logic [CMD_W-1:0] CMD_SPARE = CMD_W'(3);
  localparam int ITEMS_PER_PHASE = 167;
  localparam int DRAIN_CYCLES    = 1200;
  localparam int STALL_LIMIT     = 20000;

  typedef struct packed {
    logic [YEAR_W-1:0]      year;
    logic [MONTH_IN_W-1:0]  month;
    logic [DAY_IN_W-1:0]    day;
    logic [AMOUNT_BITS-1:0] amount;
    logic [CMD_W-1:0]       command;
  } shift_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    status_t            status;
  } shift_res_t;

  typedef struct packed {
    shift_req_t req;
    logic       fixed_en;
    shift_res_t fixed;
  } date_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [YEAR_W-1:0]      in_start_year = '0;
  logic [MONTH_IN_W-1:0]  in_start_month = '0;
  logic [DAY_IN_W-1:0]    in_start_day = '0;
  logic [AMOUNT_BITS-1:0] in_amount = '0;
  logic [CMD_W-1:0]       in_command = CMD_DAYS;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [YEAR_W-1:0]      out_result_year;
  logic [MONTH_W-1:0]     out_result_month;
  logic [DAY_W-1:0]       out_result_day;
  logic [STATUS_W-1:0]    out_status;

  logic       cur_fixed_en = 1'b0;
  shift_res_t cur_fixed = '0;
  shift_res_t want;
  shift_res_t shifted_q[$];
  date_row_t  date_table[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         in_gap_pct = 0;
  int         out_stall_pct = 0;
  int         gap_by_phase[3] = '{6, 75, 0};
  int         stall_by_phase[3] = '{75, 6, 0};

  calendar_date_shift_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_amount        (in_amount),
    .in_command       (in_command),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_status       (out_status)
  );

  always #6 clk = ~clk;

  function automatic bit is_leap(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_in_month(input longint y, input longint m);
    longint len;
    case (m)
      2:             len = is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // day 1 is 0001-01-01
  function automatic longint day_number(input longint y, input longint m, input longint d);
    longint yy;
    longint n;
    yy = y - 1;
    n  = yy * 365 + yy / 4 - yy / 100 + yy / 400 + d;
    for (longint k = 1; k < m; k++) n += days_in_month(y, k);
    return n;
  endfunction

  function automatic void date_of_day(input longint n, output longint y, output longint m,
                                      output longint d);
    longint doy;
    y = (n - 1) * 400 / 146097 + 1;
    while (day_number(y + 1, 1, 1) <= n) y++;
    while (day_number(y, 1, 1) > n) y--;
    doy = n - day_number(y, 1, 1) + 1;
    m = 1;
    while (doy > days_in_month(y, m)) begin
      doy -= days_in_month(y, m);
      m++;
    end
    d = doy;
  endfunction

  function automatic shift_res_t shift_date(input shift_req_t req);
    shift_res_t res;
    longint y, m, d, a, t, n, ry, rm, rd;
    y  = req.year;
    m  = req.month;
    d  = req.day;
    a  = longint'($signed(req.amount));
    ry = 0;
    rm = 0;
    rd = 0;
    res.status = STAT_OK;
    if (y < 1 || y > YEAR_MAX || m < 1 || m > MONTHS_PER_YEAR || d < 1 ||
        d > days_in_month(y, m)) begin
      res.status = STAT_BAD_DATE;
    end else if (req.command == CMD_MONTHS) begin
      t = y * MONTHS_PER_YEAR + m - 1 + a;
      if (t < MONTHS_PER_YEAR || t >= (YEAR_MAX + 1) * MONTHS_PER_YEAR) begin
        res.status = STAT_RANGE;
      end else begin
        ry = t / MONTHS_PER_YEAR;
        rm = t % MONTHS_PER_YEAR + 1;
        rd = d;
        if (rm == 2 && d == LEAP_DAY && !is_leap(ry)) begin
          rm = 3;
          rd = 1;
        end else if (d > days_in_month(ry, rm)) begin
          rd = days_in_month(ry, rm);
        end
      end
    end else if (req.command == CMD_YEARS) begin
      ry = y + a;
      if (ry < 1 || ry > YEAR_MAX) begin
        res.status = STAT_RANGE;
      end else begin
        rm = m;
        rd = (m == 2 && d == LEAP_DAY && !is_leap(ry)) ? 28 : d;
      end
    end else begin
      n = day_number(y, m, d) + a;
      if (n < day_number(1, 1, 1) || n > day_number(YEAR_MAX, 12, 31)) begin
        res.status = STAT_RANGE;
      end else begin
        date_of_day(n, ry, rm, rd);
      end
    end
    if (res.status != STAT_OK) begin
      ry = 0;
      rm = 0;
      rd = 0;
    end
    res.year  = YEAR_W'(ry);
    res.month = MONTH_W'(rm);
    res.day   = DAY_W'(rd);
    return res;
  endfunction

  function automatic shift_req_t random_req();
    shift_req_t r;
    int         pick;
    int         len;
    if ($urandom_range(0, 99) < 12) begin
      r.year    = YEAR_W'($urandom);
      r.month   = MONTH_IN_W'($urandom);
      r.day     = DAY_IN_W'($urandom);
      r.amount  = AMOUNT_BITS'($urandom);
      r.command = CMD_W'($urandom);
      return r;
    end
    pick = $urandom_range(0, 3);
    if (pick == 0)      r.year = YEAR_W'($urandom_range(1, 40));
    else if (pick == 1) r.year = YEAR_W'($urandom_range(YEAR_MAX - 39, YEAR_MAX));
    else                r.year = YEAR_W'($urandom_range(1, YEAR_MAX));
    r.month = MONTH_IN_W'($urandom_range(1, MONTHS_PER_YEAR));
    len     = int'(days_in_month(r.year, r.month));
    if ($urandom_range(0, 1) == 0) r.day = DAY_IN_W'($urandom_range(1, len));
    else                           r.day = DAY_IN_W'($urandom_range(28, len));
    pick = $urandom_range(0, 9);
    if (pick < 4)      r.command = CMD_DAYS;
    else if (pick < 7) r.command = CMD_MONTHS;
    else if (pick < 9) r.command = CMD_YEARS;
    else               r.command = CMD_SPARE;
    pick = $urandom_range(0, 9);
    if (pick < 4)      r.amount = AMOUNT_BITS'(int'($urandom_range(0, 128)) - 64);
    else if (pick < 7) r.amount = AMOUNT_BITS'(int'($urandom_range(0, 8000)) - 4000);
    else               r.amount = AMOUNT_BITS'($urandom);
    return r;
  endfunction

  task automatic add_row(input int y, input int m, input int d, input int amt,
                         input logic [CMD_W-1:0] cmd, input logic fixed_en,
                         input int ry, input int rm, input int rd, input status_t st);
    date_row_t row;
    row.req.year      = YEAR_W'(y);
    row.req.month     = MONTH_IN_W'(m);
    row.req.day       = DAY_IN_W'(d);
    row.req.amount    = AMOUNT_BITS'(amt);
    row.req.command   = cmd;
    row.fixed_en      = fixed_en;
    row.fixed.year    = YEAR_W'(ry);
    row.fixed.month   = MONTH_W'(rm);
    row.fixed.day     = DAY_W'(rd);
    row.fixed.status  = st;
    date_table.push_back(row);
  endtask

  task automatic send_beat(input shift_req_t req, input logic fixed_en,
                           input shift_res_t fixed);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_year  <= req.year;
    in_start_month <= req.month;
    in_start_day   <= req.day;
    in_amount      <= req.amount;
    in_command     <= req.command;
    cur_fixed_en   <= fixed_en;
    cur_fixed      <= fixed;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (shifted_q.size() != 0);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (shifted_q.size() == 0) begin
          $display("%0t: unexpected beat %0d-%0d-%0d status %0d", $time, out_result_year,
                   out_result_month, out_result_day, out_status);
          mismatches++;
        end else begin
          want = shifted_q.pop_front();
          if (out_result_year !== want.year || out_result_month !== want.month ||
              out_result_day !== want.day || out_status !== want.status) begin
            $display("%0t: expected %0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d",
                     $time, want.year, want.month, want.day, want.status, out_result_year,
                     out_result_month, out_result_day, out_status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (cur_fixed_en) begin
          shifted_q.push_back(cur_fixed);
        end else begin
          shifted_q.push_back(shift_date({in_start_year, in_start_month, in_start_day,
                                          in_amount, in_command}));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("** calendar_date_shift_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    add_row(2024, 2, 29, 1, CMD_DAYS, 1'b1, 2024, 3, 1, STAT_OK);
    add_row(2023, 12, 31, 1, CMD_DAYS, 1'b1, 2024, 1, 1, STAT_OK);
    add_row(1900, 2, 28, 1, CMD_DAYS, 1'b1, 1900, 3, 1, STAT_OK);
    add_row(2000, 2, 28, 1, CMD_SPARE, 1'b1, 2000, 2, 29, STAT_OK);
    add_row(1, 1, 1, -1, CMD_DAYS, 1'b1, 0, 0, 0, STAT_RANGE);
    add_row(9999, 12, 31, 1, CMD_DAYS, 1'b1, 0, 0, 0, STAT_RANGE);
    add_row(0, 1, 1, -5, CMD_YEARS, 1'b1, 0, 0, 0, STAT_BAD_DATE);
    add_row(16383, 127, 127, -1, CMD_SPARE, 1'b1, 0, 0, 0, STAT_BAD_DATE);
    add_row(2023, 2, 29, 1, CMD_MONTHS, 1'b1, 0, 0, 0, STAT_BAD_DATE);
    add_row(2024, 13, 1, 1, CMD_DAYS, 1'b1, 0, 0, 0, STAT_BAD_DATE);
    add_row(2024, 4, 31, 1, CMD_YEARS, 1'b1, 0, 0, 0, STAT_BAD_DATE);
    add_row(2024, 6, 0, 1, CMD_DAYS, 1'b1, 0, 0, 0, STAT_BAD_DATE);
    add_row(2024, 1, 31, 1, CMD_MONTHS, 1'b1, 2024, 2, 29, STAT_OK);
    add_row(2023, 1, 29, 1, CMD_MONTHS, 1'b1, 2023, 3, 1, STAT_OK);
    add_row(2024, 1, 29, 1, CMD_MONTHS, 1'b1, 2024, 2, 29, STAT_OK);
    add_row(2023, 3, 31, -1, CMD_MONTHS, 1'b1, 2023, 2, 28, STAT_OK);
    add_row(1, 1, 15, -1, CMD_MONTHS, 1'b1, 0, 0, 0, STAT_RANGE);
    add_row(9999, 12, 1, 1, CMD_MONTHS, 1'b1, 0, 0, 0, STAT_RANGE);
    add_row(2024, 2, 29, 1, CMD_YEARS, 1'b1, 2025, 2, 28, STAT_OK);
    add_row(2024, 2, 29, 4, CMD_YEARS, 1'b1, 2028, 2, 29, STAT_OK);
    add_row(1, 1, 1, 9998, CMD_YEARS, 1'b1, 9999, 1, 1, STAT_OK);
    add_row(9999, 1, 1, 1, CMD_YEARS, 1'b1, 0, 0, 0, STAT_RANGE);
    add_row(5000, 6, 15, -32768, CMD_YEARS, 1'b1, 0, 0, 0, STAT_RANGE);
    add_row(2000, 3, 15, 32767, CMD_DAYS, 1'b0, 0, 0, 0, STAT_OK);
    add_row(9999, 12, 31, -32768, CMD_DAYS, 1'b0, 0, 0, 0, STAT_OK);
    add_row(5000, 6, 15, 32767, CMD_MONTHS, 1'b0, 0, 0, 0, STAT_OK);
    add_row(1, 2, 28, -32768, CMD_MONTHS, 1'b0, 0, 0, 0, STAT_OK);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (date_table[i]) send_beat(date_table[i].req, date_table[i].fixed_en,
                                      date_table[i].fixed);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      in_gap_pct    = gap_by_phase[phase];
      out_stall_pct = stall_by_phase[phase];
      repeat (ITEMS_PER_PHASE) send_beat(random_req(), 1'b0, '0);
      // hold the input until every result is back
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shifted_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, shifted_q.size());
      mismatches += shifted_q.size();
    end
    if (mismatches == 0) begin
      $display("** calendar_date_shift_unit: PASSED **");
    end else begin
      $display("** calendar_date_shift_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cds_pkg.sv
rtl/cds_div12.sv
rtl/calendar_date_shift_unit.sv
tb/tb_calendar_date_shift_unit.sv
